// ----- sv/hlbc_pkg.sv -----
// hlbc_pkg: types and constants shared by the hot loop back-edge counter
// no dependencies
`timescale 1ns / 1ps

package hlbc_pkg;

  localparam int unsigned PC_W     = 64;
  localparam int unsigned HASH_W   = 32;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned PID_W    = 6;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 1'd1;

  typedef enum logic [1:0] {
    ST_COUNTED  = 2'd0,
    ST_DISABLED = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_CMP,
    BK_NEW,
    BK_UPD
  } back_state_e;

  // one queued back-edge event, tagged by the front
  typedef struct packed {
    logic [PC_W-1:0]   pc;
    logic [HASH_W-1:0] hash;
    logic              dis;
  } que_item_t;

endpackage

// ----- sv/hot_loop_backedge_counter.sv -----
// back part path: a disabled event goes straight to the result register; otherwise the search
// steps READ and CMP per slot, then UPD when found, NEW then UPD on an append, NEW alone when full
// the back part takes the next event only once it is idle and the result register is empty;
// the slot-by-slot search is set by the single table read port
// a 2-entry queue takes events while the search runs
// reset clears the fill count, queue pointers and result valid flag; table needs no clearing pass
`timescale 1ns / 1ps

module hot_loop_backedge_counter #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hlbc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hlbc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [hlbc_pkg::PC_W-1:0]       header_pc_i,
  input  logic [hlbc_pkg::HASH_W-1:0]     func_hash_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [hlbc_pkg::COUNT_W-1:0]    edge_count_o,
  output logic [hlbc_pkg::PID_W-1:0]      point_id_o,
  output logic                            compile_trigger_o,
  output logic [1:0]                      status_o
);
  import hlbc_pkg::*;

  logic [COUNT_W-1:0] thr_q;
  logic               en_q;
  que_item_t          item;
  logic               item_valid, item_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= COUNT_W'(10000);
      en_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_THRESHOLD: thr_q <= cfg_data_i[COUNT_W-1:0];
        REG_ENABLE:    en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  hlbc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .header_pc_i  (header_pc_i),
    .func_hash_i  (func_hash_i),
    .enable_i     (en_q),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  hlbc_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_i            (item),
    .item_valid_i      (item_valid),
    .item_pop_o        (item_pop),
    .threshold_i       (thr_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .edge_count_o      (edge_count_o),
    .point_id_o        (point_id_o),
    .compile_trigger_o (compile_trigger_o),
    .status_o          (status_o)
  );

endmodule

// ----- sv/hlbc_front.sv -----
// hlbc_front: accepts back-edge events, tags them and queues them
// depends on hlbc_pkg
`timescale 1ns / 1ps

module hlbc_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [hlbc_pkg::PC_W-1:0]   header_pc_i,
  input  logic [hlbc_pkg::HASH_W-1:0] func_hash_i,
  input  logic                     enable_i,
  output hlbc_pkg::que_item_t      item_o,
  output logic                     item_valid_o,
  input  logic                     item_pop_i
);
  import hlbc_pkg::*;

  que_item_t  que_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign pop          = item_pop_i && (cnt_q != 2'd0);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = que_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // monitor state is sampled at transfer
  always_ff @(posedge clk_i) begin
    if (push) begin
      que_q[wr_ptr_q] <= '{pc: header_pc_i, hash: func_hash_i, dis: !enable_i};
    end
  end

endmodule

// ----- sv/hlbc_back.sv -----
// hlbc_back: loop point table, sequential search, count update and result register
// depends on hlbc_pkg
`timescale 1ns / 1ps

module hlbc_back #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hlbc_pkg::que_item_t         item_i,
  input  logic                        item_valid_i,
  output logic                        item_pop_o,
  input  logic [hlbc_pkg::COUNT_W-1:0] threshold_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [hlbc_pkg::COUNT_W-1:0] edge_count_o,
  output logic [hlbc_pkg::PID_W-1:0]  point_id_o,
  output logic                        compile_trigger_o,
  output logic [1:0]                  status_o
);
  import hlbc_pkg::*;

  localparam int unsigned IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned USED_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned KEY_W  = PC_W + HASH_W;

  logic [KEY_W-1:0]   key_mem [MAX_POINTS];
  logic [COUNT_W-1:0] cnt_mem [MAX_POINTS];
  logic               att_mem [MAX_POINTS];

  back_state_e        state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [USED_W-1:0]  used_q, used_d;
  logic [KEY_W-1:0]   cur_key_q, cur_key_d;
  logic [COUNT_W-1:0] cur_cnt_q, cur_cnt_d;
  logic               cur_att_q, cur_att_d;
  logic [KEY_W-1:0]   rd_key_q;
  logic [COUNT_W-1:0] rd_cnt_q;
  logic               rd_att_q;

  logic               ov_q, ov_d;
  logic [COUNT_W-1:0] ocnt_q, ocnt_d;
  logic [PID_W-1:0]   opid_q, opid_d;
  logic               otrig_q, otrig_d;
  status_e            ost_q, ost_d;

  logic               key_we, upd_we;
  logic [COUNT_W-1:0] new_cnt;
  logic               trig;
  logic               last_idx;

  assign new_cnt  = (cur_cnt_q == '1) ? cur_cnt_q : cur_cnt_q + COUNT_W'(1);
  assign trig     = (new_cnt >= threshold_i) && !cur_att_q;
  assign last_idx = ({1'b0, idx_q} + (IDX_W+1)'(1)) == (IDX_W+1)'(used_q);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    used_d     = used_q;
    cur_key_d  = cur_key_q;
    cur_cnt_d  = cur_cnt_q;
    cur_att_d  = cur_att_q;
    ov_d       = ov_q && out_stall_i;
    ocnt_d     = ocnt_q;
    opid_d     = opid_q;
    otrig_d    = otrig_q;
    ost_d      = ost_q;
    item_pop_o = 1'b0;
    key_we     = 1'b0;
    upd_we     = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        // take the next event only once the result register is empty
        if (item_valid_i && !ov_q) begin
          item_pop_o = 1'b1;
          cur_key_d  = {item_i.pc, item_i.hash};
          idx_d      = '0;
          if (item_i.dis) begin
            ov_d    = 1'b1;
            ocnt_d  = '0;
            opid_d  = '0;
            otrig_d = 1'b0;
            ost_d   = ST_DISABLED;
          end else if (used_q == '0) begin
            state_d = BK_NEW;
          end else begin
            state_d = BK_READ;
          end
        end
      end
      BK_READ: state_d = BK_CMP;
      BK_CMP: begin
        if (rd_key_q == cur_key_q) begin
          cur_cnt_d = rd_cnt_q;
          cur_att_d = rd_att_q;
          state_d   = BK_UPD;
        end else if (last_idx) begin
          state_d = BK_NEW;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = BK_READ;
        end
      end
      BK_NEW: begin
        if (used_q == USED_W'(MAX_POINTS)) begin
          ov_d    = 1'b1;
          ocnt_d  = '0;
          opid_d  = '0;
          otrig_d = 1'b0;
          ost_d   = ST_FULL;
          state_d = BK_IDLE;
        end else begin
          key_we    = 1'b1;
          idx_d     = IDX_W'(used_q);
          used_d    = used_q + USED_W'(1);
          cur_cnt_d = '0;
          cur_att_d = 1'b0;
          state_d   = BK_UPD;
        end
      end
      BK_UPD: begin
        upd_we  = 1'b1;
        ov_d    = 1'b1;
        ocnt_d  = new_cnt;
        opid_d  = PID_W'(idx_q);
        otrig_d = trig;
        ost_d   = ST_COUNTED;
        state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      used_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    cur_key_q <= cur_key_d;
    cur_cnt_q <= cur_cnt_d;
    cur_att_q <= cur_att_d;
    ocnt_q    <= ocnt_d;
    opid_q    <= opid_d;
    otrig_q   <= otrig_d;
    ost_q     <= ost_d;
  end

  // table memories: one read port, one write port each
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[IDX_W'(used_q)] <= cur_key_q;
    end
    if (upd_we) begin
      cnt_mem[idx_q] <= new_cnt;
      att_mem[idx_q] <= cur_att_q || trig;
    end
    rd_key_q <= key_mem[idx_q];
    rd_cnt_q <= cnt_mem[idx_q];
    rd_att_q <= att_mem[idx_q];
  end

  assign out_valid_o       = ov_q;
  assign edge_count_o      = ocnt_q;
  assign point_id_o        = opid_q;
  assign compile_trigger_o = otrig_q;
  assign status_o          = ost_q;

endmodule

// ----- sv/hlbc_checker.sv -----
// hlbc_checker: port-level properties of the back-edge counter, bound to the top level
// depends on hlbc_pkg
`timescale 1ns / 1ps

module hlbc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [hlbc_pkg::COUNT_W-1:0]    edge_count_o,
  input logic [hlbc_pkg::PID_W-1:0]      point_id_o,
  input logic                            compile_trigger_o,
  input logic [1:0]                      status_o
);
  import hlbc_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(edge_count_o)
      && $stable(point_id_o) && $stable(compile_trigger_o) && $stable(status_o))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_COUNTED || status_o == ST_DISABLED
      || status_o == ST_FULL)
    else $error("bad status code");

  a_uncounted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_COUNTED |->
      edge_count_o == '0 && point_id_o == '0 && !compile_trigger_o)
    else $error("uncounted result carries data");

  a_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_COUNTED |-> edge_count_o != '0)
    else $error("counted result with zero count");

endmodule

bind hot_loop_backedge_counter hlbc_checker u_hlbc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .edge_count_o      (edge_count_o),
  .point_id_o        (point_id_o),
  .compile_trigger_o (compile_trigger_o),
  .status_o          (status_o)
);
